// File: hw/rtl/pidaw_pkg.sv
package pidaw_pkg;

  localparam int A_W   = 56;
  localparam int B_W   = 32;
  localparam int DEN_W = 35;
  localparam int NUM_W = 72;

  localparam logic [NUM_W-1:0] LIM_POS56 = 72'h00_007F_FFFF_FFFF_FFFF;
  localparam logic [NUM_W-1:0] LIM_POS32 = 72'h00_0000_0000_7FFF_FFFF;

  localparam logic signed [33:0] POWER_FULL = 34'sd25600;

  localparam logic [2:0] CFG_SETPOINT = 3'd0;
  localparam logic [2:0] CFG_GAIN     = 3'd1;
  localparam logic [2:0] CFG_TI       = 3'd2;
  localparam logic [2:0] CFG_TD       = 3'd3;
  localparam logic [2:0] CFG_ENABLES  = 3'd4;

  localparam logic [1:0] CLAMP_NONE = 2'd0;
  localparam logic [1:0] CLAMP_HIGH = 2'd1;
  localparam logic [1:0] CLAMP_LOW  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_CALC, S_I_GO, S_I_WAIT, S_D_GO, S_D_WAIT,
    S_SUM, S_CHK, S_B_GO, S_B_WAIT, S_FIN
  } state_e;

  typedef enum logic [1:0] {MD_INTEG, MD_DERIV, MD_BACK} md_op_e;

  typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV, MD_SAT} md_phase_e;

  typedef struct packed {
    logic   load_in;
    logic   calc;
    logic   md_start;
    md_op_e md_op;
    logic   take_i;
    logic   take_d;
    logic   do_sum;
    logic   take_b;
    logic   clear_integ;
    logic   load_out;
  } cmd_t;

  typedef struct packed {
    logic md_done;
    logic clamped;
    logic k_zero;
    logic out_free;
  } stat_t;

endpackage

// File: hw/rtl/pidaw_if.sv
interface pidaw_item_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] measured_temp;
  logic [23:0]        elapsed_us;
  modport source (output valid, measured_temp, elapsed_us, input ready);
  modport sink (input valid, measured_temp, elapsed_us, output ready);
endinterface

interface pidaw_res_if;
  logic               valid;
  logic               ready;
  logic [14:0]        power_out;
  logic signed [31:0] prop_term;
  logic signed [31:0] integ_term;
  logic signed [31:0] deriv_term;
  logic [1:0]         clamp_status;
  modport source (output valid, power_out, prop_term, integ_term, deriv_term, clamp_status,
                  input ready);
  modport sink (input valid, power_out, prop_term, integ_term, deriv_term, clamp_status,
                output ready);
endinterface

interface pidaw_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/pid_heater_loop_antiwindup.sv
// an item runs through input capture, the error terms and then two or three serial
// multiply/divide passes (integral, derivative, and a back-calculation pass when the
// output clamps and the gain is nonzero); a stalled output register holds the result back
// each pass does 32 shift-add steps, 72 restoring divide steps and a saturation step
// items are handled one at a time; a new item is taken while a result
// waits in the output register
// reset: config registers to their defaults, integral and previous error cleared, no result held
module pid_heater_loop_antiwindup import pidaw_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  pidaw_item_if.sink   item_i,
  pidaw_res_if.source  result_o,
  pidaw_cfg_if.sink    cfg_i
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_i.ready = 1'b1;

  pidaw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pidaw_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_i.valid),
    .cfg_idx_i   (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .meas_i      (item_i.measured_temp),
    .dt_i        (item_i.elapsed_us),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .power_o     (result_o.power_out),
    .prop_o      (result_o.prop_term),
    .integ_o     (result_o.integ_term),
    .deriv_o     (result_o.deriv_term),
    .status_o    (result_o.clamp_status)
  );

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |=> !item_i.ready)
    else $error("input taken while busy");

  a_power_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.power_out <= 15'd25600))
    else $error("power out of range");

  a_clamp_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.clamp_status == CLAMP_HIGH) |-> (result_o.power_out == 15'd25600))
    else $error("high clamp without full power");

  a_clamp_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.clamp_status == CLAMP_LOW) |-> (result_o.power_out == 15'd0))
    else $error("low clamp with nonzero power");

endmodule

// File: hw/rtl/pidaw_muldiv.sv
module pidaw_muldiv import pidaw_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [A_W-1:0]          a_i,
  input  logic [B_W-1:0]          b_i,
  input  logic [DEN_W-1:0]        d_i,
  input  logic                    neg_i,
  input  logic                    sat56_i,
  output logic                    done_o,
  output logic signed [A_W-1:0]   res_o
);

  md_phase_e          phase_q;
  logic [6:0]         cnt_q;
  logic [NUM_W-1:0]   a_q;
  logic [B_W-1:0]     b_q;
  logic [NUM_W-1:0]   acc_q;
  logic [DEN_W-1:0]   dv_q;
  logic [DEN_W:0]     rem_q;
  logic               neg_q;
  logic               sat56_q;
  logic               done_q;
  logic [A_W-1:0]     res_q;

  logic [DEN_W:0]     rem_sh;
  logic               fits;
  logic [NUM_W-1:0]   lim_pos;
  logic [NUM_W-1:0]   lim_neg;
  logic [NUM_W-1:0]   mag;
  logic [A_W-1:0]     res_d;

  always_comb begin
    rem_sh  = {rem_q[DEN_W-1:0], acc_q[NUM_W-1]};
    fits    = rem_sh >= {1'b0, dv_q};
    lim_pos = sat56_q ? LIM_POS56 : LIM_POS32;
    lim_neg = lim_pos + 1'b1;
    if (neg_q) begin
      mag   = (acc_q > lim_neg) ? lim_neg : acc_q;
      res_d = ~mag[A_W-1:0] + 1'b1;
    end else begin
      mag   = (acc_q > lim_pos) ? lim_pos : acc_q;
      res_d = mag[A_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (phase_q)
        MD_IDLE: begin
          if (start_i) begin
            phase_q <= MD_MUL;
            cnt_q   <= '0;
          end
        end
        MD_MUL: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 7'(B_W - 1)) begin
            phase_q <= MD_DIV;
            cnt_q   <= '0;
          end
        end
        MD_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 7'(NUM_W - 1)) begin
            phase_q <= MD_SAT;
          end
        end
        MD_SAT: begin
          phase_q <= MD_IDLE;
          done_q  <= 1'b1;
        end
        default: phase_q <= MD_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (phase_q)
      MD_IDLE: begin
        if (start_i) begin
          a_q     <= NUM_W'(a_i);
          b_q     <= b_i;
          acc_q   <= '0;
          dv_q    <= d_i;
          rem_q   <= '0;
          neg_q   <= neg_i;
          sat56_q <= sat56_i;
        end
      end
      MD_MUL: begin
        if (b_q[0]) acc_q <= acc_q + a_q;
        a_q <= {a_q[NUM_W-2:0], 1'b0};
        b_q <= {1'b0, b_q[B_W-1:1]};
      end
      MD_DIV: begin
        rem_q <= fits ? (rem_sh - {1'b0, dv_q}) : rem_sh;
        acc_q <= {acc_q[NUM_W-2:0], fits};
      end
      MD_SAT: begin
        res_q <= res_d;
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = $signed(res_q);

endmodule

// File: hw/rtl/pidaw_dp.sv
module pidaw_dp import pidaw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output stat_t              stat_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic signed [15:0] meas_i,
  input  logic [23:0]        dt_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [14:0]        power_o,
  output logic signed [31:0] prop_o,
  output logic signed [31:0] integ_o,
  output logic signed [31:0] deriv_o,
  output logic [1:0]         status_o
);

  logic signed [15:0] sp_q;
  logic [15:0]        k_q, ti_q, td_q;
  logic [2:0]         en_q;
  logic signed [15:0] meas_q;
  logic [23:0]        dt_q;
  logic signed [55:0] integ_q;
  logic signed [16:0] prev_q;
  logic signed [31:0] p_q, i_q, d_q;
  logic [31:0]        kt_q;
  logic [DEN_W-1:0]   dscale_q;
  logic [31:0]        den_q;
  logic [27:0]        de1000_q;
  logic               de_pos_q;
  logic [1:0]         clamp_q;
  logic [14:0]        pow_q;
  logic               out_valid_q;
  logic [14:0]        out_pow_q;
  logic signed [31:0] out_p_q, out_i_q, out_d_q;
  logic [1:0]         out_st_q;

  logic signed [16:0] e_w;
  logic signed [41:0] edt;
  logic signed [56:0] acc57;
  logic signed [55:0] integ_d;
  logic signed [33:0] kpe, kpe_adj;
  logic signed [17:0] de_w;
  logic [17:0]        de_abs;
  logic [15:0]        ti_eff;
  logic [23:0]        dt_eff;
  logic [A_W-1:0]     integ_abs;
  logic [B_W-1:0]     i_abs;
  logic signed [33:0] s34, exc;
  logic signed [35:0] inew;
  logic               hi, lo;
  logic               md_done;
  logic signed [A_W-1:0] md_res;
  logic [A_W-1:0]     md_a;
  logic [B_W-1:0]     md_b;
  logic [DEN_W-1:0]   md_d;
  logic               md_neg, md_sat56;

  always_comb begin
    e_w     = {sp_q[15], sp_q} - {meas_q[15], meas_q};
    edt     = e_w * $signed({1'b0, dt_q});
    acc57   = {integ_q[55], integ_q} + {{15{edt[41]}}, edt};
    if (acc57[56] != acc57[55]) integ_d = acc57[56] ? {1'b1, 55'd0} : {1'b0, {55{1'b1}}};
    else integ_d = acc57[55:0];
    kpe     = $signed({1'b0, k_q}) * e_w;
    kpe_adj = kpe + (kpe[33] ? 34'sd255 : 34'sd0);
    de_w    = {e_w[16], e_w} - {prev_q[16], prev_q};
    de_abs  = de_w[17] ? (~de_w + 1'b1) : de_w;
    ti_eff  = (ti_q == '0) ? 16'd1 : ti_q;
    dt_eff  = (dt_q == '0) ? 24'd1 : dt_q;
    integ_abs = integ_q[55] ? (~integ_q + 1'b1) : integ_q;
    i_abs     = i_q[31] ? (~i_q + 1'b1) : i_q;
    s34 = {{2{p_q[31]}}, p_q} + {{2{i_q[31]}}, i_q} + {{2{d_q[31]}}, d_q};
    hi  = s34 > POWER_FULL;
    lo  = s34[33];
    exc = hi ? (s34 - POWER_FULL) : s34;
    inew = {{4{i_q[31]}}, i_q} - {{2{exc[33]}}, exc};
    case (cmd_i.md_op)
      MD_DERIV: begin
        md_a = A_W'(kt_q); md_b = B_W'(de1000_q); md_d = DEN_W'(den_q);
        md_neg = de_pos_q; md_sat56 = 1'b0;
      end
      MD_BACK: begin
        md_a = A_W'(dscale_q); md_b = i_abs; md_d = DEN_W'(k_q);
        md_neg = i_q[31]; md_sat56 = 1'b1;
      end
      default: begin
        md_a = integ_abs; md_b = B_W'(k_q); md_d = dscale_q;
        md_neg = integ_q[55]; md_sat56 = 1'b0;
      end
    endcase
  end

  pidaw_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.md_start),
    .a_i     (md_a),
    .b_i     (md_b),
    .d_i     (md_d),
    .neg_i   (md_neg),
    .sat56_i (md_sat56),
    .done_o  (md_done),
    .res_o   (md_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      k_q         <= 16'd256;
      ti_q        <= 16'd1000;
      td_q        <= '0;
      en_q        <= 3'b111;
      integ_q     <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SETPOINT: sp_q <= $signed(cfg_data_i);
          CFG_GAIN:     k_q  <= cfg_data_i;
          CFG_TI:       ti_q <= cfg_data_i;
          CFG_TD:       td_q <= cfg_data_i;
          CFG_ENABLES:  en_q <= cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (cmd_i.calc) begin
        integ_q <= integ_d;
        prev_q  <= e_w;
      end
      if (cmd_i.take_b) integ_q <= md_res;
      if (cmd_i.clear_integ) integ_q <= '0;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.load_out) out_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      meas_q <= meas_i;
      dt_q   <= dt_i;
    end
    if (cmd_i.calc) begin
      p_q      <= en_q[0] ? 32'($signed(kpe_adj[33:8])) : '0;
      kt_q     <= 32'(k_q) * 32'(td_q);
      de1000_q <= 28'(de_abs) * 28'd1000;
      de_pos_q <= !de_w[17] && (de_w != '0);
      dscale_q <= DEN_W'(ti_eff) * DEN_W'(256000);
      den_q    <= {dt_eff, 8'h00};
    end
    if (cmd_i.take_i) i_q <= en_q[1] ? md_res[31:0] : '0;
    if (cmd_i.take_d) d_q <= en_q[2] ? md_res[31:0] : '0;
    if (cmd_i.do_sum) begin
      if (hi) begin
        clamp_q <= CLAMP_HIGH;
        pow_q   <= 15'd25600;
      end else if (lo) begin
        clamp_q <= CLAMP_LOW;
        pow_q   <= '0;
      end else begin
        clamp_q <= CLAMP_NONE;
        pow_q   <= s34[14:0];
      end
      if (hi || lo) begin
        if (inew > 36'sh0_7FFF_FFFF) i_q <= 32'sh7FFF_FFFF;
        else if (inew < -36'sh0_8000_0000) i_q <= 32'sh8000_0000;
        else i_q <= inew[31:0];
      end
    end
    if (cmd_i.load_out) begin
      out_pow_q <= pow_q;
      out_p_q   <= p_q;
      out_i_q   <= i_q;
      out_d_q   <= d_q;
      out_st_q  <= clamp_q;
    end
  end

  assign stat_o.md_done  = md_done;
  assign stat_o.clamped  = (clamp_q != CLAMP_NONE);
  assign stat_o.k_zero   = (k_q == '0);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign power_o     = out_pow_q;
  assign prop_o      = out_p_q;
  assign integ_o     = out_i_q;
  assign deriv_o     = out_d_q;
  assign status_o    = out_st_q;

endmodule

// File: hw/rtl/pidaw_ctrl.sv
module pidaw_ctrl import pidaw_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.md_op = MD_INTEG;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d = S_I_GO;
      end
      S_I_GO: begin
        cmd_o.md_start = 1'b1;
        cmd_o.md_op = MD_INTEG;
        state_d = S_I_WAIT;
      end
      S_I_WAIT: begin
        if (stat_i.md_done) begin
          cmd_o.take_i = 1'b1;
          state_d = S_D_GO;
        end
      end
      S_D_GO: begin
        cmd_o.md_start = 1'b1;
        cmd_o.md_op = MD_DERIV;
        state_d = S_D_WAIT;
      end
      S_D_WAIT: begin
        if (stat_i.md_done) begin
          cmd_o.take_d = 1'b1;
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        cmd_o.do_sum = 1'b1;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (!stat_i.clamped) begin
          state_d = S_FIN;
        end else if (stat_i.k_zero) begin
          cmd_o.clear_integ = 1'b1;
          state_d = S_FIN;
        end else begin
          state_d = S_B_GO;
        end
      end
      S_B_GO: begin
        cmd_o.md_start = 1'b1;
        cmd_o.md_op = MD_BACK;
        state_d = S_B_WAIT;
      end
      S_B_WAIT: begin
        if (stat_i.md_done) begin
          cmd_o.take_b = 1'b1;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
